// ----- sv/ebml_element_stream_parser_unit_defines.svh -----
// assertion macros for the ebml element stream parser
// used by the top level; expects clk and rst_n in scope
`ifndef EBML_ELEMENT_STREAM_PARSER_UNIT_DEFINES_SVH
`define EBML_ELEMENT_STREAM_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define EESP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define EESP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/eesp_pkg.sv -----
// shared types and constants of the ebml element stream parser
// no dependencies
`timescale 1ns / 1ps

package eesp_pkg;

  typedef enum logic [2:0] {
    PH_ID_FIRST   = 3'd0,
    PH_ID_MORE    = 3'd1,
    PH_SIZE_FIRST = 3'd2,
    PH_SIZE_MORE  = 3'd3,
    PH_PAYLOAD    = 3'd4
  } eesp_phase_t;

  typedef enum logic [1:0] {
    CFG_CONTAINER_ID  = 2'd0,
    CFG_HEADER_END_ID = 2'd1,
    CFG_PACKET_END_ID = 2'd2
  } eesp_cfg_idx_t;

  localparam logic [31:0] CONTAINER_ID_RST  = 32'h1853_8067;
  localparam logic [31:0] HEADER_END_ID_RST = 32'h1654_AE6B;
  localparam logic [31:0] PACKET_END_ID_RST = 32'h1F43_B675;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_end;
  } eesp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       header_done;
    logic       packet_done;
  } eesp_out_t;

  // parent level as kept on the stack (always in payload phase)
  typedef struct packed {
    logic [31:0] elem_id;
    logic [63:0] elem_size;
    logic [63:0] payload_count;
  } eesp_ent_t;

  typedef struct packed {
    logic      en;
    eesp_ent_t ent;
  } eesp_push_t;

  typedef struct packed {
    logic header_done;
    logic packet_done;
  } eesp_stat_t;

endpackage

// ----- sv/ebml_element_stream_parser_unit.sv -----
// top level of the ebml element stream parser: channel registers and config
// depends on eesp_pkg, eesp_stack, eesp_core and the assertion macro header
`timescale 1ns / 1ps
`include "ebml_element_stream_parser_unit_defines.svh"

// channel   direction  handshake             payload
// in_       input      in_valid / in_stall   eesp_in_t  (in_byte, chunk_end)
// out_      output     out_valid / out_stall eesp_out_t (out_byte, header_done, packet_done)
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data (32 bit)
//
// one byte a cycle sustained while out_stall is low; a byte waits in the input register, then
// enters the output register when it advances; the level walk sits between the two registers
// a completion pop, a re-dive or a dive and the byte's own decode all happen as it advances
// synchronous active-low reset clears the level state and loads the default ids
// out_stall holds the output register; in_stall rises only once the input register is full

module ebml_element_stream_parser_unit #(
  parameter int MAX_DEPTH = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  eesp_pkg::eesp_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output eesp_pkg::eesp_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int DW  = $clog2(MAX_DEPTH + 1);
  localparam int SIW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  eesp_pkg::eesp_in_t   in_r;
  logic                 in_vld_r;
  eesp_pkg::eesp_out_t  out_r;
  logic                 out_vld_r;
  logic [31:0]          container_id_r, header_end_id_r, packet_end_id_r;
  logic                 adv;

  eesp_pkg::eesp_push_t push;
  logic [SIW-1:0]       push_idx, rd_idx;
  eesp_pkg::eesp_ent_t  par;
  eesp_pkg::eesp_stat_t stat;
  logic [DW-1:0]        depth;

  assign adv       = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.out_byte    <= in_r.in_byte;
      out_r.header_done <= stat.header_done;
      out_r.packet_done <= stat.packet_done;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      container_id_r  <= eesp_pkg::CONTAINER_ID_RST;
      header_end_id_r <= eesp_pkg::HEADER_END_ID_RST;
      packet_end_id_r <= eesp_pkg::PACKET_END_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        eesp_pkg::CFG_CONTAINER_ID:  container_id_r  <= cfg_data;
        eesp_pkg::CFG_HEADER_END_ID: header_end_id_r <= cfg_data;
        eesp_pkg::CFG_PACKET_END_ID: packet_end_id_r <= cfg_data;
        default: ;
      endcase
    end
  end

  eesp_stack #(
    .MAX_DEPTH (MAX_DEPTH),
    .SIW       (SIW)
  ) u_stack (
    .clk      (clk),
    .push     (push),
    .push_idx (push_idx),
    .rd_idx   (rd_idx),
    .rd_ent   (par)
  );

  eesp_core #(
    .MAX_DEPTH (MAX_DEPTH),
    .DW        (DW),
    .SIW       (SIW)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (adv),
    .in_byte       (in_r.in_byte),
    .container_id  (container_id_r),
    .header_end_id (header_end_id_r),
    .packet_end_id (packet_end_id_r),
    .par           (par),
    .push          (push),
    .push_idx      (push_idx),
    .rd_idx        (rd_idx),
    .stat          (stat),
    .depth         (depth)
  );

  `EESP_ASSERT_NOW(a_depth_limit, 1'b1, depth <= DW'(MAX_DEPTH), "nesting depth beyond limit")
  `EESP_ASSERT_NEXT(a_depth_hold, !adv, $stable(depth), "depth moved without a byte")
  `EESP_ASSERT_NEXT(a_adv_out, adv, out_vld_r, "processed byte lost before output")
  `EESP_ASSERT_NOW(a_push_step, push.en, adv && depth < DW'(MAX_DEPTH), "stack push out of turn")

endmodule

// ----- sv/eesp_stack.sv -----
// parent level stack of the ebml element stream parser
// depends on eesp_pkg
`timescale 1ns / 1ps

module eesp_stack #(
  parameter int MAX_DEPTH = 5,
  parameter int SIW       = 3
) (
  input  logic                  clk,
  input  eesp_pkg::eesp_push_t  push,
  input  logic [SIW-1:0]        push_idx,
  input  logic [SIW-1:0]        rd_idx,
  output eesp_pkg::eesp_ent_t   rd_ent
);

  // entries only read after a push has filled them
  eesp_pkg::eesp_ent_t stk_r [MAX_DEPTH];

  always_ff @(posedge clk) begin
    if (push.en) begin
      stk_r[push_idx] <= push.ent;
    end
  end

  assign rd_ent = stk_r[rd_idx];

endmodule

// ----- sv/eesp_core.sv -----
// level walker of the ebml element stream parser: current level and depth
// depends on eesp_pkg; drives eesp_stack through a push struct
`timescale 1ns / 1ps

module eesp_core #(
  parameter int MAX_DEPTH = 5,
  parameter int DW        = 3,
  parameter int SIW       = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            in_byte,
  input  logic [31:0]           container_id,
  input  logic [31:0]           header_end_id,
  input  logic [31:0]           packet_end_id,
  input  eesp_pkg::eesp_ent_t   par,
  output eesp_pkg::eesp_push_t  push,
  output logic [SIW-1:0]        push_idx,
  output logic [SIW-1:0]        rd_idx,
  output eesp_pkg::eesp_stat_t  stat,
  output logic [DW-1:0]         depth
);

  typedef struct packed {
    eesp_pkg::eesp_phase_t phase;
    logic [31:0]           elem_id;
    logic [2:0]            id_length;
    logic [2:0]            id_index;
    logic [63:0]           elem_size;
    logic [3:0]            size_length;
    logic [3:0]            size_index;
    logic [63:0]           payload_count;
  } lvl_t;

  lvl_t            cur_r, cur_nxt;
  logic [DW-1:0]   depth_r, depth_nxt;
  logic [DW-1:0]   depth_m1;
  logic            is_pay, done, cur_cont, par_cont;

  function automatic logic [2:0] lead4(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 4; i < 8; i++) begin
      if (b[i]) n = 3'(8 - i);
    end
    return n;
  endfunction

  function automatic logic [3:0] lead8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(8 - i);
    end
    return n;
  endfunction

  function automatic lvl_t consume(input lvl_t c, input logic [7:0] b);
    lvl_t       r;
    logic [2:0] n4;
    logic [3:0] n8;
    r  = c;
    n4 = lead4(b);
    n8 = lead8(b);
    unique case (c.phase)
      eesp_pkg::PH_ID_MORE: begin
        if (!c.id_index[2]) begin
          unique case (c.id_index[1:0])
            2'd0: r.elem_id[31:24] = c.elem_id[31:24] | b;
            2'd1: r.elem_id[23:16] = c.elem_id[23:16] | b;
            2'd2: r.elem_id[15:8]  = c.elem_id[15:8]  | b;
            default: r.elem_id[7:0] = c.elem_id[7:0] | b;
          endcase
        end
        r.id_index = c.id_index + 3'd1;
        if (r.id_index >= c.id_length) r.phase = eesp_pkg::PH_SIZE_FIRST;
      end
      eesp_pkg::PH_SIZE_FIRST: begin
        r.elem_size = 64'd0;
        if (n8 != 4'd0) begin
          r.size_length = n8;
          r.size_index  = 4'd1;
          r.elem_size   = {56'd0, b & (8'hFF >> n8)};
          r.phase = (n8 == 4'd1) ? eesp_pkg::PH_PAYLOAD : eesp_pkg::PH_SIZE_MORE;
        end
      end
      eesp_pkg::PH_SIZE_MORE: begin
        r.elem_size  = {c.elem_size[55:0], b};
        r.size_index = c.size_index + 4'd1;
        if (r.size_index >= c.size_length) r.phase = eesp_pkg::PH_PAYLOAD;
      end
      default: begin
        // first id octet; an octet with no marker bit keeps this phase
        r.payload_count = 64'd0;
        r.elem_id       = {b, 24'd0};
        r.id_index      = 3'd1;
        if (n4 != 3'd0) begin
          r.id_length = n4;
          r.phase = (n4 == 3'd1) ? eesp_pkg::PH_SIZE_FIRST : eesp_pkg::PH_ID_MORE;
        end else begin
          r.phase = eesp_pkg::PH_ID_FIRST;
        end
      end
    endcase
    return r;
  endfunction

  function automatic lvl_t fresh(input lvl_t c, input logic [7:0] b);
    lvl_t r;
    r       = c;
    r.phase = eesp_pkg::PH_ID_FIRST;
    return consume(r, b);
  endfunction

  assign depth_m1 = depth_r - DW'(1);
  assign rd_idx   = depth_m1[SIW-1:0];
  assign push_idx = depth_r[SIW-1:0];

  // levels below the current one are always in payload and never complete,
  // levels above it always wait for a first id octet
  assign is_pay   = (cur_r.phase == eesp_pkg::PH_PAYLOAD);
  assign done     = is_pay && (cur_r.payload_count == cur_r.elem_size);
  assign cur_cont = (cur_r.elem_id == container_id);
  assign par_cont = (depth_r != '0) && (par.elem_id == container_id);

  assign stat.header_done = done && (cur_r.elem_id == header_end_id);
  assign stat.packet_done = done && (cur_r.elem_id == packet_end_id);

  always_comb begin
    cur_nxt   = cur_r;
    depth_nxt = depth_r;
    push.en   = 1'b0;
    push.ent.elem_id       = cur_r.elem_id;
    push.ent.elem_size     = cur_r.elem_size;
    push.ent.payload_count = cur_r.payload_count;
    priority if (!is_pay) begin
      cur_nxt = consume(cur_r, in_byte);
    end else if (done && (depth_r == '0 || par_cont)) begin
      // completed; with no parent or a container parent, this level starts the next element with this byte
      cur_nxt = fresh(cur_r, in_byte);
    end else if (done) begin
      // completed; plain parent takes the byte as payload
      cur_nxt.phase         = eesp_pkg::PH_PAYLOAD;
      cur_nxt.elem_id       = par.elem_id;
      cur_nxt.elem_size     = par.elem_size;
      cur_nxt.payload_count = par.payload_count + 64'd1;
      depth_nxt             = depth_m1;
    end else if (cur_cont && (depth_r < DW'(MAX_DEPTH))) begin
      push.en   = step;
      cur_nxt   = fresh(cur_r, in_byte);
      depth_nxt = depth_r + DW'(1);
    end else begin
      cur_nxt.payload_count = cur_r.payload_count + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      depth_r <= '0;
    end else if (step) begin
      cur_r   <= cur_nxt;
      depth_r <= depth_nxt;
    end
  end

  assign depth = depth_r;

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench of the ebml element stream parser: directed and random element streams
// it predicts every output byte and its completion flags, and checks them against the output channel
// depends on eesp_pkg and the top level ebml_element_stream_parser_unit
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH_LIMIT = 5;
  localparam int LEVELS = DEPTH_LIMIT + 1;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [7:0] octet_q_t [$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  eesp_pkg::eesp_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  eesp_pkg::eesp_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // register copies seen by the parser model
  logic [31:0] cont_id = eesp_pkg::CONTAINER_ID_RST;
  logic [31:0] hdr_id = eesp_pkg::HEADER_END_ID_RST;
  logic [31:0] pkt_id = eesp_pkg::PACKET_END_ID_RST;

  // per-level parse state
  int unsigned cur_level = 0;
  eesp_pkg::eesp_phase_t lvl_phase [LEVELS] = '{default: eesp_pkg::PH_ID_FIRST};
  logic [31:0] lvl_id [LEVELS] = '{default: '0};
  logic [2:0] lvl_id_len [LEVELS] = '{default: '0};
  logic [2:0] lvl_id_idx [LEVELS] = '{default: '0};
  logic [63:0] lvl_size [LEVELS] = '{default: '0};
  logic [3:0] lvl_size_len [LEVELS] = '{default: '0};
  logic [3:0] lvl_size_idx [LEVELS] = '{default: '0};
  logic [63:0] lvl_count [LEVELS] = '{default: '0};

  eesp_pkg::eesp_in_t stream_q [$];
  eesp_pkg::eesp_out_t parsed_q [$];
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_left = 0;
  logic hold_go = 1'b0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;

  ebml_element_stream_parser_unit #(
    .MAX_DEPTH(DEPTH_LIMIT)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // position of the leading one bit, 0 when none within maxlen
  function automatic int unsigned marker_len(input logic [7:0] b, input int unsigned maxlen);
    for (int unsigned n = 1; n <= maxlen; n++) begin
      if (b[8 - n]) return n;
    end
    return 0;
  endfunction

  // walks the level stack for one byte and returns the byte with its completion flags
  function automatic eesp_pkg::eesp_out_t parse_byte(input logic [7:0] b);
    eesp_pkg::eesp_out_t res;
    int unsigned lv;
    int unsigned n;
    res = '0;
    res.out_byte = b;
    for (int g = 0; g < 2 * DEPTH_LIMIT + 4; g++) begin
      lv = cur_level;
      if (lvl_phase[lv] == eesp_pkg::PH_PAYLOAD) begin
        if (lvl_count[lv] == lvl_size[lv]) begin
          if (lvl_id[lv] == hdr_id) res.header_done = 1'b1;
          if (lvl_id[lv] == pkt_id) res.packet_done = 1'b1;
          lvl_phase[lv] = eesp_pkg::PH_ID_FIRST;
          if (lv > 0) cur_level = lv - 1;
          continue;
        end
        if (lvl_id[lv] == cont_id && lv < DEPTH_LIMIT) begin
          cur_level = lv + 1;
          continue;
        end
        lvl_count[lv]++;
        break;
      end
      unique case (lvl_phase[lv])
        eesp_pkg::PH_ID_MORE: begin
          if (lvl_id_idx[lv] < 4) lvl_id[lv] |= 32'(b) << ((3 - lvl_id_idx[lv]) * 8);
          lvl_id_idx[lv]++;
          if (lvl_id_idx[lv] >= lvl_id_len[lv]) lvl_phase[lv] = eesp_pkg::PH_SIZE_FIRST;
        end
        eesp_pkg::PH_SIZE_FIRST: begin
          n = marker_len(b, 8);
          lvl_size[lv] = '0;
          if (n != 0) begin
            lvl_size_len[lv] = 4'(n);
            lvl_size_idx[lv] = 4'd1;
            lvl_size[lv] = 64'(b & (8'hFF >> n));
            if (n == 1) lvl_phase[lv] = eesp_pkg::PH_PAYLOAD;
            else lvl_phase[lv] = eesp_pkg::PH_SIZE_MORE;
          end
        end
        eesp_pkg::PH_SIZE_MORE: begin
          lvl_size[lv] = {lvl_size[lv][55:0], b};
          lvl_size_idx[lv]++;
          if (lvl_size_idx[lv] >= lvl_size_len[lv]) lvl_phase[lv] = eesp_pkg::PH_PAYLOAD;
        end
        default: begin
          lvl_count[lv] = '0;
          lvl_id[lv] = {b, 24'h0};
          lvl_id_idx[lv] = 3'd1;
          n = marker_len(b, 4);
          if (n == 0) begin
            lvl_phase[lv] = eesp_pkg::PH_ID_FIRST;
          end else begin
            lvl_id_len[lv] = 3'(n);
            if (n == 1) lvl_phase[lv] = eesp_pkg::PH_SIZE_FIRST;
            else lvl_phase[lv] = eesp_pkg::PH_ID_MORE;
          end
        end
      endcase
      break;
    end
    return res;
  endfunction

  // size vint, mostly of minimal length, sometimes padded out to more octets
  function automatic octet_q_t encode_vint(input logic [63:0] v);
    octet_q_t q;
    int unsigned n;
    n = 1;
    while (n < 8 && v >= (64'd1 << (7 * n))) n++;
    if ($urandom_range(3) == 0) n = n + $urandom_range(1, 3);
    if (n > 8) n = 8;
    for (int i = int'(n) - 1; i >= 0; i--) q.push_back(v[8 * i +: 8]);
    q[0] = q[0] | (8'h80 >> (n - 1));
    return q;
  endfunction

  // one well-formed element at the given level; containers below the depth limit hold zero or more children
  function automatic octet_q_t build_element(input int unsigned lvl);
    octet_q_t q;
    octet_q_t body;
    octet_q_t kid;
    logic [31:0] id;
    int sel;
    int unsigned n;
    int unsigned kids;
    int unsigned len;
    sel = int'($urandom_range(99));
    if (sel < 25 - 4 * int'(lvl)) id = cont_id;
    else if (sel < 40) id = hdr_id;
    else if (sel < 55) id = pkt_id;
    else begin
      n = $urandom_range(1, 4);
      id = $urandom;
      id[31:24] = (id[31:24] & (8'hFF >> n)) | (8'h80 >> (n - 1));
    end
    n = marker_len(id[31:24], 4);
    if (n == 0) begin
      id = {8'h80 | 8'($urandom_range(127)), 24'h0};
      n = 1;
    end
    id = id & ~(32'hFFFF_FFFF >> (8 * n));
    for (int i = 0; i < int'(n); i++) q.push_back(id[31 - 8 * i -: 8]);
    if (id == cont_id && lvl < DEPTH_LIMIT) begin
      kids = $urandom_range(0, (lvl < 2) ? 3 : 1);
      for (int k = 0; k < int'(kids); k++) begin
        kid = build_element(lvl + 1);
        body = {body, kid};
      end
    end else begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      for (int i = 0; i < int'(len); i++) body.push_back(8'($urandom));
    end
    // a zero size lead octet is dropped by the parser while it waits for a real one
    if ($urandom_range(19) == 0) q.push_back(8'h00);
    kid = encode_vint(64'(body.size()));
    q = {q, kid, body};
    return q;
  endfunction

  task automatic push_octets(input octet_q_t seq);
    eesp_pkg::eesp_in_t item;
    foreach (seq[i]) begin
      item.in_byte = seq[i];
      item.chunk_end = ($urandom_range(7) == 0);
      stream_q.push_back(item);
    end
  endtask

  task automatic queue_stream(input int unsigned count);
    octet_q_t seq;
    int unsigned made;
    made = 0;
    while (made < count) begin
      seq.delete();
      // stray bytes without a marker bit where an id should start
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom_range(15)));
      end
      seq = {seq, build_element(0)};
      push_octets(seq);
      made += seq.size();
    end
  endtask

  task automatic program_reg(input eesp_pkg::eesp_cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    unique case (idx)
      eesp_pkg::CFG_CONTAINER_ID: cont_id = val;
      eesp_pkg::CFG_HEADER_END_ID: hdr_id = val;
      eesp_pkg::CFG_PACKET_END_ID: pkt_id = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    while (stream_q.size() != 0 || in_valid || parsed_q.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (stream_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_data <= stream_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_go) hold_left <= 120;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // watches both channels: predicts on input transfers, checks on output transfers
  always @(posedge clk) begin : watch
    eesp_pkg::eesp_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) parsed_q.push_back(parse_byte(in_data.in_byte));
      if (out_valid && !out_stall) begin
        if (parsed_q.size() == 0) begin
          if (fault_count < 10)
            $display("unexpected output transfer: byte %02h header_done %0b packet_done %0b",
                     out_data.out_byte, out_data.header_done, out_data.packet_done);
          fault_count++;
        end else begin
          want = parsed_q.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.header_done !== want.header_done ||
              out_data.packet_done !== want.packet_done) begin
            if (fault_count < 10)
              $display("mismatch: byte %02h/%02h header_done %0b/%0b packet_done %0b/%0b",
                       want.out_byte, out_data.out_byte, want.header_done, out_data.header_done,
                       want.packet_done, out_data.packet_done);
            fault_count++;
          end
        end
      end
    end
    out_stall <= rst_n && ((hold_left != 0) || ($urandom_range(99) < recv_idle));
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    octet_q_t seq;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle <= 14;
    recv_idle <= 81;

    // reset ids: header end of size zero, then packet end of size zero, both completing
    @(negedge clk);
    seq = {8'h16, 8'h54, 8'hAE, 8'h6B, 8'h80, 8'h1F, 8'h43, 8'hB6, 8'h75, 8'h80};
    push_octets(seq);
    settle();

    program_reg(eesp_pkg::CFG_CONTAINER_ID, 32'h8100_0000);
    program_reg(eesp_pkg::CFG_HEADER_END_ID, 32'h8200_0000);
    // invalid id lead, six nested containers (the deepest one is plain payload),
    // then a header end with a zero size lead before its real size
    @(negedge clk);
    seq = {8'h00, 8'h81, 8'h8B, 8'h81, 8'h89, 8'h81, 8'h87, 8'h81, 8'h85, 8'h81, 8'h83,
           8'h81, 8'h81, 8'hFF, 8'h82, 8'h00, 8'h80};
    push_octets(seq);
    queue_stream(300);
    settle();

    send_idle <= 81;
    recv_idle <= 14;
    program_reg(eesp_pkg::CFG_CONTAINER_ID, eesp_pkg::CONTAINER_ID_RST);
    program_reg(eesp_pkg::CFG_HEADER_END_ID, eesp_pkg::HEADER_END_ID_RST);
    program_reg(eesp_pkg::CFG_PACKET_END_ID, 32'hA300_0000);
    @(negedge clk);
    queue_stream(300);
    settle();

    send_idle <= 0;
    recv_idle <= 0;
    program_reg(eesp_pkg::CFG_CONTAINER_ID, 32'hFFFF_FFFF);
    program_reg(eesp_pkg::CFG_HEADER_END_ID, 32'h0000_0000);
    program_reg(eesp_pkg::CFG_PACKET_END_ID, 32'h4286_0000);
    @(negedge clk);
    queue_stream(100);
    settle();

    program_reg(eesp_pkg::CFG_CONTAINER_ID, 32'h20AB_CD00);
    program_reg(eesp_pkg::CFG_HEADER_END_ID, 32'h10AA_BBCC);
    program_reg(eesp_pkg::CFG_PACKET_END_ID, 32'h8100_0000);
    // long output hold while the sender keeps offering, so the input side backs up
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    @(negedge clk);
    queue_stream(200);
    settle();

    if (fault_count == 0 && parsed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
